// File: rtl/tof_height_rate_estimator_top_defines.svh
// Assertion macros for the height and rate estimator top level.
// Expects clk and arst_n in the scope of the including module.
`ifndef TOF_HEIGHT_RATE_ESTIMATOR_TOP_DEFINES_SVH
`define TOF_HEIGHT_RATE_ESTIMATOR_TOP_DEFINES_SVH

// Check a condition in the same cycle.
`define THRE_ASSERT_NOW(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check a condition in the next cycle.
`define THRE_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/thre_pkg.sv
// Package for the height and rate estimator: widths, constants, codes, state type.
// No dependencies.
`timescale 1ns / 1ps

package thre_pkg;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 15;

	localparam int HEIGHT_W = 13;
	localparam int RATE_W   = 24;
	localparam int COUNT_W  = 8;
	localparam int SCALE_W  = 10;
	localparam int CLAMP_W  = 15;
	localparam int ALPHA_W  = 9;
	localparam int DIFF_W   = 14;
	localparam int RAW_W    = 16;
	localparam int MARK_MIN_W = 14;

	localparam int MUL_A_W = 25;
	localparam int MUL_B_W = 11;
	localparam int MUL_P_W = MUL_A_W + MUL_B_W;

	localparam int ALPHA_SHIFT = 8;

	localparam logic [MARK_MIN_W-1:0] INVALID_MARK = 14'd8192;
	localparam logic [HEIGHT_W-1:0]   HEIGHT_MAX   = 13'd8191;
	localparam logic [COUNT_W-1:0]    ERR_SAT      = 8'd255;
	localparam logic [ALPHA_W-1:0]    ALPHA_ONE    = 9'd256;
	localparam int                    RATE_LIMIT   = 8388352;

	localparam logic [COUNT_W-1:0] DECIMATION_RST   = 8'd20;
	localparam logic [COUNT_W-1:0] ERROR_LIMIT_RST  = 8'd30;
	localparam logic [SCALE_W-1:0] RATE_SCALE_RST   = 10'd50;
	localparam logic [CLAMP_W-1:0] RATE_CLAMP_RST   = 15'd3000;
	localparam logic [ALPHA_W-1:0] FILTER_ALPHA_RST = 9'd77;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DECIMATION   = 3'd0,
		REG_ERROR_LIMIT  = 3'd1,
		REG_RATE_SCALE   = 3'd2,
		REG_RATE_CLAMP   = 3'd3,
		REG_FILTER_ALPHA = 3'd4
	} thre_reg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECODE,
		ST_RAW,
		ST_FB,
		ST_NEW,
		ST_SUM,
		ST_DONE
	} thre_state_t;

endpackage

// File: rtl/thre_ifs.sv
// Channel interfaces: sensor tick input, result output, register write port.
// Depends on thre_pkg.
`timescale 1ns / 1ps

interface thre_in_if #(parameter int DIST_BITS = 14);
	logic                 valid;
	logic                 ready;
	logic [DIST_BITS-1:0] distance_mm;
	logic                 restart;

	modport source (output valid, output distance_mm, output restart, input ready);
	modport sink (input valid, input distance_mm, input restart, output ready);
endinterface

interface thre_out_if;
	logic                                 valid;
	logic                                 ready;
	logic                                 sampled;
	logic                                 new_sample;
	logic [thre_pkg::HEIGHT_W-1:0]        height_mm;
	logic signed [thre_pkg::RATE_W-1:0]   height_rate;
	logic                                 reset_request;
	logic [thre_pkg::COUNT_W-1:0]         error_count;

	modport source (output valid, output sampled, output new_sample, output height_mm,
		output height_rate, output reset_request, output error_count, input ready);
	modport sink (input valid, input sampled, input new_sample, input height_mm,
		input height_rate, input reset_request, input error_count, output ready);
endinterface

interface thre_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [thre_pkg::CFG_IDX_W-1:0]  index;
	logic [thre_pkg::CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// File: rtl/tof_height_rate_estimator_top.sv
// Height and vertical rate estimator: decimation, error tracking, rate low-pass.
// Depends on thre_pkg, thre_ifs, thre_mul and the assertion macro header.
//
//   channel      role    width of payload
//   sample_in    sink    DIST_BITS + 1
//   result_out   source  48
//   cfg          sink    3 + 15
//
// A tick that is no sensor read, an invalid read or a first read goes from decode
// straight to done. A valid read with tracking in place makes three passes through the
// one shared multiplier, then the sum and saturation.
// arst_n clears all tracking state and loads the register defaults.
// A pending result stalls the sequencer only when the next one is finished.
`timescale 1ns / 1ps
`include "tof_height_rate_estimator_top_defines.svh"

module tof_height_rate_estimator_top #(
	parameter int DIST_BITS = 14,
	parameter int FRAC_BITS = 8
) (
	input  logic       clk,
	input  logic       arst_n,
	thre_in_if.sink    sample_in,
	thre_out_if.source result_out,
	thre_cfg_if.sink   cfg
);
	import thre_pkg::*;

	localparam int MARK_W = (DIST_BITS > MARK_MIN_W) ? DIST_BITS : MARK_MIN_W;
	localparam int SUM_W  = MUL_P_W + FRAC_BITS + 1;

	thre_state_t state_q, state_d;

	logic [COUNT_W-1:0] decimation_q, error_limit_q;
	logic [SCALE_W-1:0] rate_scale_q;
	logic [CLAMP_W-1:0] rate_clamp_q;
	logic [ALPHA_W-1:0] filter_alpha_q;

	logic [COUNT_W-1:0]        tick_q, bad_q;
	logic                      synced_q, reinit_q;
	logic [HEIGHT_W-1:0]       cur_height_q, prev_height_q;
	logic signed [RATE_W-1:0]  rate_filter_q, rate_out_q;
	logic                      sampled_q, fresh_q;

	logic [DIST_BITS-1:0]       dist_q;
	logic                       restart_q;
	logic signed [DIFF_W-1:0]   diff_q;
	logic signed [RAW_W-1:0]    raw_q;
	logic signed [MUL_P_W-1:0]  acc_q;

	logic                      out_valid_q;
	logic                      res_sampled_q, res_fresh_q, res_reinit_q;
	logic [HEIGHT_W-1:0]       res_height_q;
	logic signed [RATE_W-1:0]  res_rate_q;
	logic [COUNT_W-1:0]        res_count_q;

	logic                      in_acc, load_out;
	logic signed [MUL_A_W-1:0] mul_a;
	logic signed [MUL_B_W-1:0] mul_b;
	logic signed [MUL_P_W-1:0] mul_p;

	logic                      eff_synced, eff_pend;
	logic [COUNT_W-1:0]        eff_bad, tick_next, bad_inc;
	logic [HEIGHT_W-1:0]       eff_prev, height_sat;
	logic [MARK_W-1:0]         dist_ext;
	logic                      read_tick, invalid;
	logic [ALPHA_W-1:0]        a_eff, one_minus;

	logic signed [MUL_P_W-1:0] lim_pos, lim_neg, raw_clamped;
	logic signed [SUM_W-1:0]   sum, shifted, rl_pos, rl_neg, sat;

	thre_mul u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p   (mul_p)
	);

	// decode of one tick
	always_comb begin
		eff_synced = restart_q ? 1'b0 : synced_q;
		eff_pend   = restart_q ? 1'b0 : reinit_q;
		eff_bad    = restart_q ? '0 : bad_q;
		eff_prev   = restart_q ? '0 : prev_height_q;
		tick_next  = tick_q + COUNT_W'(1);
		read_tick  = (tick_next >= decimation_q);
		dist_ext   = MARK_W'(dist_q);
		invalid    = (dist_ext == MARK_W'(INVALID_MARK));
		height_sat = (dist_ext > MARK_W'(HEIGHT_MAX)) ? HEIGHT_MAX : dist_ext[HEIGHT_W-1:0];
		bad_inc    = (eff_bad < ERR_SAT) ? eff_bad + COUNT_W'(1) : eff_bad;
		a_eff      = (filter_alpha_q > ALPHA_ONE) ? ALPHA_ONE : filter_alpha_q;
		one_minus  = ALPHA_ONE - a_eff;
	end

	// clamp and filter arithmetic
	always_comb begin
		lim_pos     = signed'({{(MUL_P_W-CLAMP_W){1'b0}}, rate_clamp_q});
		lim_neg     = -lim_pos;
		raw_clamped = (mul_p > lim_pos) ? lim_pos : ((mul_p < lim_neg) ? lim_neg : mul_p);
		sum         = SUM_W'(acc_q) + (SUM_W'(mul_p) <<< FRAC_BITS);
		shifted     = sum >>> ALPHA_SHIFT;
		rl_pos      = SUM_W'(RATE_LIMIT);
		rl_neg      = -rl_pos;
		sat         = (shifted > rl_pos) ? rl_pos : ((shifted < rl_neg) ? rl_neg : shifted);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d         = state_q;
		sample_in.ready = 1'b0;
		load_out        = 1'b0;
		mul_a           = '0;
		mul_b           = '0;
		in_acc          = 1'b0;
		case (state_q)
			ST_IDLE: begin
				sample_in.ready = 1'b1;
				in_acc          = sample_in.valid;
				if (sample_in.valid) begin
					state_d = ST_DECODE;
				end
			end
			ST_DECODE: begin
				if (read_tick && !invalid && eff_synced) begin
					state_d = ST_RAW;
				end else begin
					state_d = ST_DONE;
				end
			end
			ST_RAW: begin
				mul_a   = MUL_A_W'(diff_q);
				mul_b   = signed'({1'b0, rate_scale_q});
				state_d = ST_FB;
			end
			ST_FB: begin
				mul_a   = MUL_A_W'(rate_filter_q);
				mul_b   = signed'({2'b0, one_minus});
				state_d = ST_NEW;
			end
			ST_NEW: begin
				mul_a   = MUL_A_W'(raw_q);
				mul_b   = signed'({2'b0, a_eff});
				state_d = ST_SUM;
			end
			ST_SUM: begin
				state_d = ST_DONE;
			end
			ST_DONE: begin
				load_out = !out_valid_q || result_out.ready;
				if (load_out) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// register writes
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			decimation_q   <= DECIMATION_RST;
			error_limit_q  <= ERROR_LIMIT_RST;
			rate_scale_q   <= RATE_SCALE_RST;
			rate_clamp_q   <= RATE_CLAMP_RST;
			filter_alpha_q <= FILTER_ALPHA_RST;
		end else if (cfg.valid) begin
			case (thre_reg_t'(cfg.index))
				REG_DECIMATION:   decimation_q   <= cfg.data[COUNT_W-1:0];
				REG_ERROR_LIMIT:  error_limit_q  <= cfg.data[COUNT_W-1:0];
				REG_RATE_SCALE:   rate_scale_q   <= cfg.data[SCALE_W-1:0];
				REG_RATE_CLAMP:   rate_clamp_q   <= cfg.data[CLAMP_W-1:0];
				REG_FILTER_ALPHA: filter_alpha_q <= cfg.data[ALPHA_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// tracking state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q        <= '0;
			bad_q         <= '0;
			synced_q      <= 1'b0;
			reinit_q      <= 1'b0;
			cur_height_q  <= '0;
			prev_height_q <= '0;
			rate_filter_q <= '0;
			rate_out_q    <= '0;
			sampled_q     <= 1'b0;
			fresh_q       <= 1'b0;
		end else begin
			case (state_q)
				ST_DECODE: begin
					synced_q      <= eff_synced;
					bad_q         <= eff_bad;
					reinit_q      <= eff_pend;
					prev_height_q <= eff_prev;
					tick_q        <= tick_next;
					sampled_q     <= 1'b0;
					fresh_q       <= 1'b0;
					if (restart_q) begin
						rate_out_q <= '0;
					end
					if (read_tick) begin
						tick_q    <= '0;
						sampled_q <= 1'b1;
						if (invalid) begin
							bad_q    <= bad_inc;
							reinit_q <= eff_pend | (bad_inc > error_limit_q);
						end else begin
							fresh_q       <= 1'b1;
							bad_q         <= '0;
							cur_height_q  <= height_sat;
							prev_height_q <= height_sat;
							if (!eff_synced) begin
								rate_out_q <= '0;
								synced_q   <= 1'b1;
							end
						end
					end
				end
				ST_SUM: begin
					rate_filter_q <= sat[RATE_W-1:0];
					rate_out_q    <= sat[RATE_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// operand and partial result holding
	always_ff @(posedge clk) begin
		if (in_acc) begin
			dist_q    <= sample_in.distance_mm;
			restart_q <= sample_in.restart;
		end
		if (state_q == ST_DECODE) begin
			diff_q <= signed'({1'b0, height_sat}) - signed'({1'b0, eff_prev});
		end
		if (state_q == ST_FB) begin
			raw_q <= raw_clamped[RAW_W-1:0];
		end
		if (state_q == ST_NEW) begin
			acc_q <= mul_p;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (result_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			res_sampled_q <= sampled_q;
			res_fresh_q   <= fresh_q;
			res_height_q  <= cur_height_q;
			res_rate_q    <= rate_out_q;
			res_reinit_q  <= reinit_q;
			res_count_q   <= bad_q;
		end
	end

	assign result_out.valid         = out_valid_q;
	assign result_out.sampled       = res_sampled_q;
	assign result_out.new_sample    = res_fresh_q;
	assign result_out.height_mm     = res_height_q;
	assign result_out.height_rate   = res_rate_q;
	assign result_out.reset_request = res_reinit_q;
	assign result_out.error_count   = res_count_q;

	`THRE_ASSERT_NEXT(a_filter_hold, state_q != ST_SUM, $stable(rate_filter_q), "filter moved outside sum step")
	`THRE_ASSERT_NEXT(a_request_sticky, reinit_q && !(state_q == ST_DECODE && restart_q), reinit_q, "reset request dropped without restart")
	`THRE_ASSERT_NOW(a_rate_range, result_out.valid, (res_rate_q <= RATE_W'(RATE_LIMIT)) && (res_rate_q >= -RATE_W'(RATE_LIMIT)), "rate outside saturation range")
	`THRE_ASSERT_NOW(a_fresh_sampled, result_out.valid && result_out.new_sample, result_out.sampled && (result_out.error_count == '0), "valid reading without read tick or with errors")

endmodule

// File: rtl/thre_mul.sv
// Shared signed multiplier with registered product.
// Depends on thre_pkg.
`timescale 1ns / 1ps

module thre_mul (
	input  logic                                 clk,
	input  logic signed [thre_pkg::MUL_A_W-1:0]  a,
	input  logic signed [thre_pkg::MUL_B_W-1:0]  b,
	output logic signed [thre_pkg::MUL_P_W-1:0]  p
);
	import thre_pkg::*;

	always_ff @(posedge clk) begin
		p <= MUL_P_W'(a) * MUL_P_W'(b);
	end

endmodule
